// File: hdl/gll_pkg.sv
// shared types and constants of the least-loaded assigner
package gll_pkg;

    localparam int SIZE_W    = 31;
    localparam int LOAD_W    = 48;
    localparam int CPU_W     = 6;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int COUNT_W   = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NUM_DOMAINS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEV_LIMIT   = 2'd1;

    localparam logic [CFG_W-1:0] NUM_DOMAINS_RST = 7'd1;
    localparam logic [CFG_W-1:0] DEV_LIMIT_RST   = 7'd5;
    localparam logic [CFG_W-1:0] PERCENT_SCALE   = 7'd100;

    typedef struct packed {
        logic [SIZE_W-1:0] box_size;
        logic              last_box;
    } box_t;

    typedef struct packed {
        logic [CPU_W-1:0] cpu;
        logic             job_done;
        logic             balanced;
    } res_t;

    // shared unit operations
    localparam logic [2:0] ALU_NOP       = 3'd0;
    localparam logic [2:0] ALU_MIN_FIRST = 3'd1;
    localparam logic [2:0] ALU_MIN_NEXT  = 3'd2;
    localparam logic [2:0] ALU_SUM_FIRST = 3'd3;
    localparam logic [2:0] ALU_SUM_NEXT  = 3'd4;
    localparam logic [2:0] ALU_MUL       = 3'd5;
    localparam logic [2:0] ALU_DIFF      = 3'd6;
    localparam logic [2:0] ALU_CHECK     = 3'd7;

    // multiplier operand selects
    localparam logic [1:0] SRC_SUM  = 2'd0;
    localparam logic [1:0] SRC_MAX  = 2'd1;
    localparam logic [1:0] SRC_MIN  = 2'd2;
    localparam logic [1:0] SRC_DIFF = 2'd3;

    localparam logic [1:0] FAC_LIMIT   = 2'd0;
    localparam logic [1:0] FAC_DOMAINS = 2'd1;
    localparam logic [1:0] FAC_PERCENT = 2'd2;

    typedef struct packed {
        logic [2:0] op;
        logic [1:0] a_sel;
        logic [1:0] b_sel;
        logic       to_lim;
    } alu_ctl_t;

    typedef struct packed {
        logic ok;
        logic sum_zero;
    } alu_stat_t;

endpackage

// File: hdl/gll_load_mem.sv
// per-processor load memory, zeroed by a clearing pass after reset and after each job
module gll_load_mem #(
    parameter int MAX_DOMAINS = 64
) (
    input  logic                                               clk,
    input  logic                                               rst_n,
    input  logic                                               clear,
    output logic                                               init_busy,
    input  logic                                               wr_en,
    input  logic [((MAX_DOMAINS > 1) ? $clog2(MAX_DOMAINS) : 1)-1:0] wr_addr,
    input  logic [gll_pkg::LOAD_W-1:0]                         wr_data,
    input  logic                                               rd_en,
    input  logic [((MAX_DOMAINS > 1) ? $clog2(MAX_DOMAINS) : 1)-1:0] rd_addr,
    output logic [gll_pkg::LOAD_W-1:0]                         rd_data
);
    import gll_pkg::*;

    localparam int IDX_W = (MAX_DOMAINS > 1) ? $clog2(MAX_DOMAINS) : 1;

    logic [LOAD_W-1:0]  mem [MAX_DOMAINS];
    logic [LOAD_W-1:0]  rd_word_reg;
    logic               init_busy_reg;
    logic [IDX_W-1:0]   init_cnt_reg;

    logic               we_int;
    logic [IDX_W-1:0]   waddr_int;
    logic [LOAD_W-1:0]  wdata_int;

    // one entry zeroed per cycle, all MAX_DOMAINS entries per pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_busy_reg <= 1'b1;
            init_cnt_reg  <= '0;
        end
        else
        begin
            if (clear)
            begin
                init_busy_reg <= 1'b1;
                init_cnt_reg  <= '0;
            end
            else if (init_busy_reg)
            begin
                init_cnt_reg <= init_cnt_reg + 1'b1;
                if (init_cnt_reg == IDX_W'(MAX_DOMAINS - 1))
                begin
                    init_busy_reg <= 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        we_int    = wr_en;
        waddr_int = wr_addr;
        wdata_int = wr_data;
        if (init_busy_reg)
        begin
            we_int    = 1'b1;
            waddr_int = init_cnt_reg;
            wdata_int = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we_int)
        begin
            mem[waddr_int] <= wdata_int;
        end
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    assign rd_data   = rd_word_reg;
    assign init_busy = init_busy_reg;

endmodule

// File: hdl/gll_alu.sv
// shared compare, accumulate and multiply unit
module gll_alu #(
    parameter int MAX_DOMAINS = 64
) (
    input  logic                                               clk,
    input  gll_pkg::alu_ctl_t                                  ctl,
    input  logic [gll_pkg::LOAD_W-1:0]                         data,
    input  logic [((MAX_DOMAINS > 1) ? $clog2(MAX_DOMAINS) : 1)-1:0] idx,
    input  logic [$clog2(MAX_DOMAINS + 1)-1:0]                 n,
    input  logic [gll_pkg::CFG_W-1:0]                          limit,
    output logic [((MAX_DOMAINS > 1) ? $clog2(MAX_DOMAINS) : 1)-1:0] min_idx,
    output gll_pkg::alu_stat_t                                 stat
);
    import gll_pkg::*;

    localparam int IDX_W  = (MAX_DOMAINS > 1) ? $clog2(MAX_DOMAINS) : 1;
    localparam int N_W    = $clog2(MAX_DOMAINS + 1);
    localparam int SUM_W  = LOAD_W + N_W;
    localparam int B_W    = (N_W > CFG_W) ? N_W : CFG_W;
    localparam int CMP_W  = SUM_W + CFG_W;
    localparam int PROD_W = SUM_W + B_W;

    logic [SUM_W-1:0]  acc_reg;
    logic [LOAD_W-1:0] min_reg;
    logic [LOAD_W-1:0] max_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [CMP_W-1:0]  prod_reg;
    logic [CMP_W-1:0]  lim_reg;
    logic [SUM_W-1:0]  diff_reg;
    logic              ok_reg;

    logic [SUM_W-1:0]  mul_a;
    logic [B_W-1:0]    mul_b;
    logic [PROD_W-1:0] mul_p;
    logic [CMP_W-1:0]  acc_ext;
    logic [CMP_W-1:0]  diff_full;

    always_comb
    begin
        case (ctl.a_sel)
            SRC_SUM:  mul_a = acc_reg;
            SRC_MAX:  mul_a = SUM_W'(max_reg);
            SRC_MIN:  mul_a = SUM_W'(min_reg);
            SRC_DIFF: mul_a = diff_reg;
            default:  mul_a = '0;
        endcase
        case (ctl.b_sel)
            FAC_LIMIT:   mul_b = B_W'(limit);
            FAC_DOMAINS: mul_b = B_W'(n);
            FAC_PERCENT: mul_b = B_W'(PERCENT_SCALE);
            default:     mul_b = '0;
        endcase
    end

    assign mul_p     = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign acc_ext   = CMP_W'(acc_reg);
    assign diff_full = (prod_reg >= acc_ext) ? (prod_reg - acc_ext) : (acc_ext - prod_reg);

    always_ff @(posedge clk)
    begin
        case (ctl.op)
            ALU_MIN_FIRST:
            begin
                min_reg <= data;
                idx_reg <= idx;
            end
            ALU_MIN_NEXT:
            begin
                // strict compare keeps the lowest index on ties
                if (data < min_reg)
                begin
                    min_reg <= data;
                    idx_reg <= idx;
                end
            end
            ALU_SUM_FIRST:
            begin
                acc_reg <= SUM_W'(data);
                min_reg <= data;
                max_reg <= data;
                ok_reg  <= 1'b1;
            end
            ALU_SUM_NEXT:
            begin
                acc_reg <= acc_reg + SUM_W'(data);
                if (data < min_reg)
                begin
                    min_reg <= data;
                end
                if (data > max_reg)
                begin
                    max_reg <= data;
                end
            end
            ALU_MUL:
            begin
                if (ctl.to_lim)
                begin
                    lim_reg <= mul_p[CMP_W-1:0];
                end
                else
                begin
                    prod_reg <= mul_p[CMP_W-1:0];
                end
            end
            ALU_DIFF:
            begin
                diff_reg <= diff_full[SUM_W-1:0];
            end
            ALU_CHECK:
            begin
                if (prod_reg > lim_reg)
                begin
                    ok_reg <= 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign min_idx       = idx_reg;
    assign stat.ok       = ok_reg;
    assign stat.sum_zero = (acc_reg == '0);

endmodule

// File: hdl/greedy_least_loaded_assigner_core.sv
// least-loaded processor assigner: sequencer, config registers and result register
//
//  channel | direction | handshake              | payload
//  box     | in        | box_valid / box_stall  | box (box_size, last_box)
//  res     | out       | res_valid / res_stall  | res (cpu, job_done, balanced)
//  cfg     | in        | cfg_we                 | cfg_index, cfg_data
//
// n = effective domain count. an item among the first n of a job goes through read, write
// and done; a later item first runs the minimum search (one load per cycle through the
// single read port of the load memory) and a pick; a last item adds the sum pass and the
// balance test on the shared multiplier.
// after reset and after each last item the load memory is cleared, box_stall high.
// a finished result waits in the output register while the next item is taken.
module greedy_least_loaded_assigner_core #(
    parameter int MAX_DOMAINS = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             box_valid,
    output logic                             box_stall,
    input  gll_pkg::box_t                    box,
    output logic                             res_valid,
    input  logic                             res_stall,
    output gll_pkg::res_t                    res,
    input  logic                             cfg_we,
    input  logic [gll_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gll_pkg::CFG_W-1:0]        cfg_data
);
    import gll_pkg::*;

    localparam int IDX_W  = (MAX_DOMAINS > 1) ? $clog2(MAX_DOMAINS) : 1;
    localparam int N_W    = $clog2(MAX_DOMAINS + 1);
    localparam int EXT_W  = (N_W > CFG_W) ? N_W : CFG_W;
    localparam int CPUX_W = (IDX_W > CPU_W) ? IDX_W : CPU_W;
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] CHECK_LAST = 4'd8;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_PICK  = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_WRITE = 3'd4;
    localparam logic [2:0] S_SUM   = 3'd5;
    localparam logic [2:0] S_CHECK = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    // balance test: lim = limit*sum, then for max and min: n*L, |n*L - sum|, *100, compare
    function automatic alu_ctl_t check_plan(input logic [STEP_W-1:0] step);
        alu_ctl_t c;
        c = '0;
        case (step)
            4'd0: c = '{op: ALU_MUL, a_sel: SRC_SUM, b_sel: FAC_LIMIT, to_lim: 1'b1};
            4'd1: c = '{op: ALU_MUL, a_sel: SRC_MAX, b_sel: FAC_DOMAINS, to_lim: 1'b0};
            4'd2: c.op = ALU_DIFF;
            4'd3: c = '{op: ALU_MUL, a_sel: SRC_DIFF, b_sel: FAC_PERCENT, to_lim: 1'b0};
            4'd4: c.op = ALU_CHECK;
            4'd5: c = '{op: ALU_MUL, a_sel: SRC_MIN, b_sel: FAC_DOMAINS, to_lim: 1'b0};
            4'd6: c.op = ALU_DIFF;
            4'd7: c = '{op: ALU_MUL, a_sel: SRC_DIFF, b_sel: FAC_PERCENT, to_lim: 1'b0};
            4'd8: c.op = ALU_CHECK;
            default: c.op = ALU_NOP;
        endcase
        return c;
    endfunction

    logic [CFG_W-1:0]   num_domains_reg;
    logic [CFG_W-1:0]   dev_limit_reg;

    logic [2:0]         state_reg, state_next;
    logic [N_W-1:0]     cnt_reg, cnt_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [IDX_W-1:0]   c_reg, c_next;
    logic [COUNT_W-1:0] items_seen_reg, items_seen_next;
    logic [SIZE_W-1:0]  size_reg;
    logic               last_reg;
    logic               dly_v_reg, dly_first_reg, dly_last_reg;
    logic [IDX_W-1:0]   dly_idx_reg;
    logic               res_valid_reg, res_valid_next;
    res_t               res_reg, res_next;

    logic [EXT_W-1:0]   nd_ext;
    logic [N_W-1:0]     n_eff;
    logic               accept;
    logic               issue;
    logic               init_busy;
    logic               mem_clear;
    logic               mem_we;
    logic               mem_re;
    logic [IDX_W-1:0]   mem_raddr;
    logic [LOAD_W-1:0]  mem_rdata;
    logic [LOAD_W:0]    add_full;
    logic [LOAD_W-1:0]  load_sat;
    logic               enough;
    logic [CPUX_W-1:0]  c_ext;
    alu_ctl_t           alu_ctl;
    alu_stat_t          alu_stat;
    logic [IDX_W-1:0]   alu_idx;

    assign nd_ext = EXT_W'(num_domains_reg);
    assign n_eff  = (nd_ext == '0) ? N_W'(1) :
                    (nd_ext > EXT_W'(MAX_DOMAINS)) ? N_W'(MAX_DOMAINS) : N_W'(nd_ext);

    assign box_stall = (state_reg != S_IDLE) || init_busy;
    assign accept    = box_valid && !box_stall;
    assign issue     = ((state_reg == S_SCAN) || (state_reg == S_SUM)) && (cnt_reg < n_eff);

    assign add_full = {1'b0, mem_rdata} + (LOAD_W + 1)'(size_reg);
    assign load_sat = add_full[LOAD_W] ? {LOAD_W{1'b1}} : add_full[LOAD_W-1:0];
    assign enough   = (items_seen_reg >= COUNT_W'(n_eff));
    assign c_ext    = CPUX_W'(c_reg);

    assign mem_re    = issue || (state_reg == S_READ);
    assign mem_raddr = (state_reg == S_READ) ? c_reg : cnt_reg[IDX_W-1:0];
    assign mem_we    = (state_reg == S_WRITE);
    assign mem_clear = (state_reg == S_DONE) && (!res_valid_reg || !res_stall) && last_reg;

    always_comb
    begin
        alu_ctl = '0;
        case (state_reg)
            S_SCAN:
            begin
                if (dly_v_reg)
                begin
                    alu_ctl.op = dly_first_reg ? ALU_MIN_FIRST : ALU_MIN_NEXT;
                end
            end
            S_SUM:
            begin
                if (dly_v_reg)
                begin
                    alu_ctl.op = dly_first_reg ? ALU_SUM_FIRST : ALU_SUM_NEXT;
                end
            end
            S_CHECK: alu_ctl = check_plan(step_reg);
            default: alu_ctl = '0;
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        step_next       = step_reg;
        c_next          = c_reg;
        items_seen_next = items_seen_reg;
        res_valid_next  = res_valid_reg && res_stall;
        res_next        = res_reg;
        if (issue)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cnt_next = '0;
                    if (items_seen_reg < COUNT_W'(n_eff))
                    begin
                        c_next     = items_seen_reg[IDX_W-1:0];
                        state_next = S_READ;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (dly_v_reg && dly_last_reg)
                begin
                    state_next = S_PICK;
                end
            end
            S_PICK:
            begin
                c_next     = alu_idx;
                state_next = S_READ;
            end
            S_READ:
            begin
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                if (items_seen_reg != {COUNT_W{1'b1}})
                begin
                    items_seen_next = items_seen_reg + 1'b1;
                end
                cnt_next   = '0;
                state_next = last_reg ? S_SUM : S_DONE;
            end
            S_SUM:
            begin
                if (dly_v_reg && dly_last_reg)
                begin
                    step_next  = '0;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == CHECK_LAST)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next    = 1'b1;
                    res_next.cpu      = c_ext[CPU_W-1:0];
                    res_next.job_done = last_reg;
                    res_next.balanced = last_reg && enough && !alu_stat.sum_zero && alu_stat.ok;
                    if (last_reg)
                    begin
                        items_seen_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_domains_reg <= NUM_DOMAINS_RST;
            dev_limit_reg   <= DEV_LIMIT_RST;
            state_reg       <= S_IDLE;
            cnt_reg         <= '0;
            step_reg        <= '0;
            items_seen_reg  <= '0;
            dly_v_reg       <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == REG_NUM_DOMAINS))
            begin
                num_domains_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == REG_DEV_LIMIT))
            begin
                dev_limit_reg <= cfg_data;
            end
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            step_reg       <= step_next;
            items_seen_reg <= items_seen_next;
            dly_v_reg      <= issue;
            res_valid_reg  <= res_valid_next;
        end
    end

    // payload and read-pipeline tags
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            size_reg <= box.box_size;
            last_reg <= box.last_box;
        end
        c_reg         <= c_next;
        res_reg       <= res_next;
        dly_first_reg <= (cnt_reg == '0);
        dly_last_reg  <= (cnt_reg == n_eff - 1'b1);
        dly_idx_reg   <= cnt_reg[IDX_W-1:0];
    end

    gll_load_mem #(
        .MAX_DOMAINS (MAX_DOMAINS)
    ) u_load_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (mem_clear),
        .init_busy (init_busy),
        .wr_en     (mem_we),
        .wr_addr   (c_reg),
        .wr_data   (load_sat),
        .rd_en     (mem_re),
        .rd_addr   (mem_raddr),
        .rd_data   (mem_rdata)
    );

    gll_alu #(
        .MAX_DOMAINS (MAX_DOMAINS)
    ) u_alu (
        .clk     (clk),
        .ctl     (alu_ctl),
        .data    (mem_rdata),
        .idx     (dly_idx_reg),
        .n       (n_eff),
        .limit   (dev_limit_reg),
        .min_idx (alu_idx),
        .stat    (alu_stat)
    );

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// File: hdl/gll_checker.sv
// port-level checks of the assigner, bound to the top level
module gll_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          box_valid,
    input logic          box_stall,
    input gll_pkg::box_t box,
    input logic          res_valid,
    input logic          res_stall,
    input gll_pkg::res_t res
);
    import gll_pkg::*;

    logic box_take;
    assign box_take = box_valid && !box_stall;

    // block goes busy right after it takes an item
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        box_take |=> box_stall)
        else $error("block took an item and did not go busy");

    // a result never appears the cycle after a take
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        box_take |=> !$rose(res_valid))
        else $error("result appeared one cycle after an item was taken");

    // balanced only reported with the job end
    a_balanced_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.balanced) |-> res.job_done)
        else $error("balanced set on an item that is not the last");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_stall) |=> (res_valid && $stable(res)))
        else $error("stalled result dropped or changed");

endmodule

bind greedy_least_loaded_assigner_core gll_checker u_gll_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .box_valid (box_valid),
    .box_stall (box_stall),
    .box       (box),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);

// File: dv/greedy_least_loaded_assigner_core_tb.sv
// self-checking testbench for the least-loaded processor assigner core
`timescale 1ns / 100ps

// tracks processor loads and queues the assignment each accepted item must produce
class assign_tracker;
    localparam int NPROC = 64;

    logic [gll_pkg::LOAD_W-1:0]  loads [NPROC];
    logic [gll_pkg::COUNT_W-1:0] seen;
    logic [gll_pkg::CFG_W-1:0]   domains;
    logic [gll_pkg::CFG_W-1:0]   limit_pct;
    gll_pkg::res_t               pending_q [$];
    int                          errors;

    function new();
        foreach (loads[i]) loads[i] = '0;
        seen      = '0;
        domains   = gll_pkg::NUM_DOMAINS_RST;
        limit_pct = gll_pkg::DEV_LIMIT_RST;
        errors    = 0;
    endfunction

    function void write_reg(logic [gll_pkg::CFG_IDX_W-1:0] idx, logic [gll_pkg::CFG_W-1:0] val);
        if (idx == gll_pkg::REG_NUM_DOMAINS)
            domains = val;
        else if (idx == gll_pkg::REG_DEV_LIMIT)
            limit_pct = val;
    endfunction

    function int unsigned active_domains();
        if (domains == 0)
            return 1;
        if (domains > NPROC)
            return NPROC;
        return 32'(domains);
    endfunction

    function void take_box(gll_pkg::box_t b);
        logic [gll_pkg::LOAD_W-1:0] load_max;
        logic [gll_pkg::LOAD_W-1:0] size_x;
        int unsigned                n;
        int unsigned                c;
        logic [63:0]                sum;
        logic [63:0]                scaled;
        logic [63:0]                dev;
        logic [127:0]               bound;
        logic [127:0]               lhs;
        gll_pkg::res_t              r;
        load_max = '1;
        size_x   = '0;
        size_x[gll_pkg::SIZE_W-1:0] = b.box_size;
        n = active_domains();
        if (seen < n)
        begin
            c = seen;
        end
        else
        begin
            c = 0;
            for (int i = 1; i < n; i++)
                if (loads[i] < loads[c])
                    c = i;
        end
        if (load_max - loads[c] < size_x)
            loads[c] = load_max;
        else
            loads[c] = loads[c] + size_x;
        if (seen != '1)
            seen = seen + 1'b1;
        r.cpu      = c[gll_pkg::CPU_W-1:0];
        r.job_done = b.last_box;
        r.balanced = 1'b0;
        if (b.last_box)
        begin
            if (seen >= n)
            begin
                sum = '0;
                for (int i = 0; i < n; i++)
                    sum = sum + 64'(loads[i]);
                if (sum != 0)
                begin
                    r.balanced = 1'b1;
                    bound = 128'(sum);
                    bound = bound * 128'(limit_pct);
                    for (int i = 0; i < n; i++)
                    begin
                        scaled = 64'(loads[i]);
                        scaled = scaled * 64'(n);
                        dev = (scaled > sum) ? scaled - sum : sum - scaled;
                        lhs = 128'(dev);
                        lhs = lhs * 128'(100);
                        if (lhs > bound)
                            r.balanced = 1'b0;
                    end
                end
            end
            foreach (loads[i]) loads[i] = '0;
            seen = '0;
        end
        pending_q.push_back(r);
    endfunction

    function void check_assignment(gll_pkg::res_t got);
        gll_pkg::res_t exp;
        if (pending_q.size() == 0)
        begin
            $display("%0t: unexpected result, expected none, got cpu %0d done %0b bal %0b",
                     $time, got.cpu, got.job_done, got.balanced);
            errors++;
            return;
        end
        exp = pending_q.pop_front();
        if (got.cpu !== exp.cpu)
        begin
            $display("%0t: cpu mismatch, expected %0d, got %0d", $time, exp.cpu, got.cpu);
            errors++;
        end
        if (got.job_done !== exp.job_done)
        begin
            $display("%0t: job_done mismatch, expected %0b, got %0b",
                     $time, exp.job_done, got.job_done);
            errors++;
        end
        if (got.balanced !== exp.balanced)
        begin
            $display("%0t: balanced mismatch, expected %0b, got %0b",
                     $time, exp.balanced, got.balanced);
            errors++;
        end
    endfunction
endclass

module greedy_least_loaded_assigner_core_tb;
    import gll_pkg::*;

    localparam int MAX_DOM        = 64;
    localparam int LONG_HOLD      = 300;
    localparam int RANDOM_END     = 1020;
    localparam int QUIET_ITEMS    = 150;
    localparam int DRAIN_CYCLES   = 200;
    localparam int TIMEOUT_CYCLES = 2_000_000;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
    localparam logic [SIZE_W-1:0]    SIZE_MAX    = '1;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 box_valid = 1'b0;
    logic                 box_stall;
    box_t                 box       = '0;
    logic                 res_valid;
    logic                 res_stall = 1'b0;
    res_t                 res;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    assign_tracker tracker;
    int            boxes_sent = 0;
    int            cycles     = 0;
    bit            gaps_on    = 1'b0;
    bit            stall_on   = 1'b0;
    bit            hold_req   = 1'b0;
    int            hold_left  = 0;
    int            stall_left = 0;

    greedy_least_loaded_assigner_core #(
        .MAX_DOMAINS(MAX_DOM)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .box_valid(box_valid),
        .box_stall(box_stall),
        .box      (box),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res      (res),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #5 clk = ~clk;

    // result side: check accepted items, then decide the stall for the next cycle
    always @(posedge clk)
    begin
        if (res_valid && !res_stall)
            tracker.check_assignment(res);
        if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            res_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            res_stall <= 1'b1;
        end
        else if (stall_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 3);
            res_stall <= 1'b1;
        end
        else
        begin
            res_stall <= 1'b0;
        end
    end

    initial
    begin
        while (cycles < TIMEOUT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic send_box(input logic [SIZE_W-1:0] size, input logic last);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            box_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        box_valid <= 1'b1;
        box       <= {size, last};
        @(posedge clk);
        while (box_stall)
            @(posedge clk);
        tracker.take_box(box);
        boxes_sent++;
    endtask

    task automatic wait_idle();
        box_valid <= 1'b0;
        while (tracker.pending_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        tracker.write_reg(idx, val);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [CFG_W-1:0] pick_domains();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return CFG_W'($urandom_range(1, 8));
        if (r < 8)
            return CFG_W'($urandom_range(9, 20));
        if (r == 8)
        begin
            case ($urandom_range(0, 2))
                0: return 7'd0;
                1: return 7'd64;
                default: return CFG_W'($urandom_range(65, 127));
            endcase
        end
        return CFG_W'($urandom_range(0, 127));
    endfunction

    function automatic logic [CFG_W-1:0] pick_limit();
        case ($urandom_range(0, 4))
            0: return 7'd0;
            1: return 7'd100;
            2: return 7'd127;
            3: return CFG_W'($urandom_range(0, 20));
            default: return CFG_W'($urandom_range(0, 127));
        endcase
    endfunction

    // one job: mostly descending sizes, some equal-size, unsorted or short jobs
    task automatic run_job();
        int unsigned n;
        int unsigned kind;
        int unsigned len;
        int unsigned split;
        int unsigned step;
        int unsigned dec;
        logic [31:0] val;
        logic        last;
        n    = tracker.active_domains();
        kind = $urandom_range(0, 19);
        if (kind < 12)
            len = n + $urandom_range(0, 2 * n + 4);
        else if (kind < 15)
            len = n * $urandom_range(1, 3);
        else if (kind < 18)
            len = $urandom_range(1, 2 * n + 2);
        else
            len = (n > 1) ? $urandom_range(1, n - 1) : 1;
        split = (len > 1 && $urandom_range(0, 9) == 0) ? $urandom_range(1, len - 1) : 0;
        val   = $urandom_range(0, 1) ? ($urandom & 32'h7FFF_FFFF) : $urandom_range(1, 5000);
        step  = val / len + 1;
        for (int k = 0; k < len; k++)
        begin
            last = (k == len - 1);
            // domain count changes while the job is open
            if (split != 0 && k == split)
            begin
                wait_idle();
                write_cfg(REG_NUM_DOMAINS, pick_domains());
            end
            if (kind < 12)
            begin
                send_box(val[SIZE_W-1:0], last);
                dec = $urandom_range(0, step);
                val = (val > dec) ? val - dec : 0;
            end
            else if (kind < 15)
            begin
                send_box(val[SIZE_W-1:0], last);
            end
            else
            begin
                send_box(SIZE_W'($urandom), last);
            end
        end
    endtask

    initial
    begin
        int job_no;
        tracker = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero total under the reset settings
        send_box('0, 1'b1);
        wait_idle();
        // domain count zero acts as one
        write_cfg(REG_NUM_DOMAINS, 7'd0);
        send_box(SIZE_MAX, 1'b1);
        wait_idle();
        // equal loads pass even with a zero limit
        write_cfg(REG_NUM_DOMAINS, 7'd4);
        write_cfg(REG_DEV_LIMIT, 7'd0);
        repeat (3) send_box(31'h2AAA_AAAA, 1'b0);
        send_box(31'h2AAA_AAAA, 1'b1);
        wait_idle();
        // fewer items than domains
        write_cfg(REG_NUM_DOMAINS, 7'd3);
        write_cfg(REG_DEV_LIMIT, 7'd100);
        send_box(31'h5555_5555, 1'b0);
        send_box(31'd7, 1'b1);
        wait_idle();
        // count above the maximum saturates, limit above 100
        write_cfg(REG_NUM_DOMAINS, 7'd127);
        write_cfg(REG_DEV_LIMIT, 7'd127);
        send_box(31'd300, 1'b0);
        send_box(31'd200, 1'b0);
        send_box(31'd100, 1'b1);
        wait_idle();
        // min search under a long result hold, then a smaller count mid-job
        write_cfg(REG_NUM_DOMAINS, 7'd4);
        hold_req = 1'b1;
        send_box(31'd9, 1'b0);
        send_box(31'd8, 1'b0);
        send_box(31'd7, 1'b0);
        send_box(31'd6, 1'b0);
        send_box(31'd5, 1'b0);
        wait_idle();
        write_cfg(REG_NUM_DOMAINS, 7'd2);
        send_box(31'd4, 1'b0);
        send_box(31'd3, 1'b1);
        wait_idle();
        // writes to unused indexes change nothing
        write_cfg(REG_SPARE_2, 7'h7F);
        write_cfg(REG_SPARE_3, 7'h00);
        send_box(31'd50, 1'b0);
        send_box(31'd50, 1'b1);

        job_no = 0;
        while (boxes_sent < RANDOM_END)
        begin
            job_no++;
            if (boxes_sent > RANDOM_END - QUIET_ITEMS)
            begin
                gaps_on  = 1'b0;
                stall_on = 1'b0;
            end
            else
            begin
                gaps_on  = ($urandom_range(0, 3) != 0);
                stall_on = ($urandom_range(0, 3) != 0);
            end
            if (job_no == 1 || $urandom_range(0, 2) == 0)
            begin
                wait_idle();
                write_cfg(REG_NUM_DOMAINS, pick_domains());
                write_cfg(REG_DEV_LIMIT, pick_limit());
            end
            // result side holds off while items keep coming
            if (job_no == 4)
                hold_req = 1'b1;
            run_job();
        end
        gaps_on  = 1'b0;
        stall_on = 1'b0;

        // a second processor joins while the job is open
        wait_idle();
        write_cfg(REG_NUM_DOMAINS, 7'd1);
        write_cfg(REG_DEV_LIMIT, 7'd100);
        send_box(SIZE_MAX, 1'b0);
        wait_idle();
        write_cfg(REG_NUM_DOMAINS, 7'd2);
        send_box(31'd10, 1'b0);
        send_box(31'd1, 1'b0);
        send_box(31'd3, 1'b1);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.pending_q.size() != 0)
            $display("%0t: %0d expected results never arrived",
                     $time, tracker.pending_q.size());
        if (tracker.errors == 0 && tracker.pending_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: sim.f
hdl/gll_pkg.sv
hdl/gll_load_mem.sv
hdl/gll_alu.sv
hdl/greedy_least_loaded_assigner_core.sv
hdl/gll_checker.sv
dv/greedy_least_loaded_assigner_core_tb.sv
